// File: hdl/gdv_pkg.sv
package gdv_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DAY   = 2'd1;
  localparam logic [1:0] ST_BAD_MONTH = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam logic [3:0]  MONTH_JAN = 4'd0;
  localparam logic [3:0]  MONTH_FEB = 4'd1;
  localparam logic [3:0]  MONTH_DEC = 4'd11;
  localparam logic [15:0] YEAR_MAX  = 16'hFFFF;
  localparam logic [4:0]  DAY_LAST  = 5'd31;
  localparam logic [4:0]  REM_TOP   = 5'd24;
  // ceil(2^21 / 25): floor(year * RECIP_25 / 2^21) is year / 25 for any 16-bit year
  localparam logic [16:0] RECIP_25  = 17'd83887;

  typedef struct packed {
    logic [5:0]  in_day;
    logic [3:0]  in_month;
    logic [15:0] in_year;
    logic [15:0] days_to_add;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_leap;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       mod_step;
    logic [4:0] mod_rem;
    logic       incr;
  } year_cmd_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/gregorian_date_validate_add_days_core.sv
// Gregorian date check and day adder.
// Input channel: item_valid / item_stall / item (date plus days to add).
// Output channel: result_valid / result_stall / result (status, leap flag, date).
// One beat in gives exactly one beat out, in order.
// Steps: the year is reduced mod 25 (reciprocal multiply, then subtract),
// the date is checked, the days are added, then the walk steps one month
// at a time until the day fits its month or the year overflows, and the
// result is loaded into the output register. An invalid date skips the
// add and the walk.
// One shared ALU does every step but the multiply, so one item is in flight at a
// time; item_stall is high from acceptance until the result is loaded into
// the output register, and the next beat can be taken the cycle after.
// The output register lets the next item be accepted while a result still
// waits; if result_stall holds, the finished item waits for the output register.
// Reset (rst, synchronous, active high) empties the output register and
// returns the sequencer to idle.
module gregorian_date_validate_add_days_core #(
  parameter int DAYS_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  gdv_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output gdv_pkg::result_t result
);

  localparam int AddW = (DAYS_WIDTH < 16) ? DAYS_WIDTH : 16;
  localparam int AccW = AddW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state;
  logic            cnt;
  logic [4:0]      quo;
  logic [AccW-1:0] day;
  logic [3:0]      mon;
  logic [AddW-1:0] add;
  logic            leap_in;
  logic [1:0]      status;

  logic               alu_add;
  logic [AccW-1:0]    alu_a;
  logic [AccW-1:0]    alu_b;
  logic [AccW-1:0]    alu_res;
  logic               alu_gt;
  gdv_pkg::year_cmd_t trk_cmd;
  logic [15:0]        year;
  logic               leap;
  logic [4:0]         len;
  logic [32:0]        prod;
  logic [4:0]         quo_x25;
  logic               bad;
  logic               out_load;

  gdv_alu #(.W(AccW)) u_alu (
    .op_add (alu_add),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .gt     (alu_gt)
  );

  gdv_year_trk u_year (
    .clk       (clk),
    .cmd       (trk_cmd),
    .load_year (item.in_year),
    .year      (year),
    .leap      (leap)
  );

  assign item_stall = (state != S_IDLE);
  assign len        = gdv_pkg::month_len(mon, leap);
  assign prod       = 33'(year) * 33'(gdv_pkg::RECIP_25);
  // low bits of quotient * 25; year - 25 * quotient is below 25
  assign quo_x25    = {quo[0], 4'd0} + {quo[1:0], 3'd0} + quo;
  assign bad        = (status == gdv_pkg::ST_BAD_DAY) || (status == gdv_pkg::ST_BAD_MONTH);
  assign out_load   = (state == S_DONE) && (!result_valid || !result_stall);

  always_comb begin
    alu_add = 1'b0;
    alu_a   = day;
    alu_b   = AccW'(len);
    trk_cmd = '0;
    unique case (state)
      S_IDLE: begin
        trk_cmd.load = item_valid;
      end
      S_MOD: begin
        alu_a            = AccW'(year[4:0]);
        alu_b            = AccW'(quo_x25);
        trk_cmd.mod_step = !cnt;
        trk_cmd.mod_rem  = alu_res[4:0];
      end
      S_ADD: begin
        alu_add = 1'b1;
        alu_b   = AccW'(add);
      end
      S_WALK: begin
        trk_cmd.incr = alu_gt && (mon == gdv_pkg::MONTH_DEC) && (year != gdv_pkg::YEAR_MAX);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            day   <= AccW'(item.in_day);
            mon   <= item.in_month;
            add   <= item.days_to_add[AddW-1:0];
            cnt   <= 1'b1;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (cnt) begin
            quo <= prod[25:21];
            cnt <= 1'b0;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          leap_in <= leap;
          if (mon > gdv_pkg::MONTH_DEC) begin
            status <= gdv_pkg::ST_BAD_MONTH;
            state  <= S_DONE;
          end else if ((day == '0) || alu_gt) begin
            status <= gdv_pkg::ST_BAD_DAY;
            state  <= S_DONE;
          end else begin
            status <= gdv_pkg::ST_OK;
            state  <= S_ADD;
          end
        end
        S_ADD: begin
          day   <= alu_res;
          state <= S_WALK;
        end
        S_WALK: begin
          if (!alu_gt) begin
            state <= S_DONE;
          end else if (mon == gdv_pkg::MONTH_DEC) begin
            if (year == gdv_pkg::YEAR_MAX) begin
              status <= gdv_pkg::ST_OVERFLOW;
              day    <= AccW'(gdv_pkg::DAY_LAST);
              state  <= S_DONE;
            end else begin
              day <= alu_res;
              mon <= gdv_pkg::MONTH_JAN;
            end
          end else begin
            day <= alu_res;
            mon <= mon + 4'd1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            result.status    <= status;
            result.is_leap   <= leap_in;
            result.out_day   <= bad ? 5'd0 : day[4:0];
            result.out_month <= bad ? 4'd0 : mon;
            result.out_year  <= bad ? 16'd0 : year;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_ovf_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == gdv_pkg::ST_OVERFLOW) |->
      (result.out_year == gdv_pkg::YEAR_MAX) && (result.out_month == gdv_pkg::MONTH_DEC) &&
      (result.out_day == gdv_pkg::DAY_LAST))
    else $error("overflow result not held at last date");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((result.status == gdv_pkg::ST_BAD_DAY) ||
                     (result.status == gdv_pkg::ST_BAD_MONTH)) |->
      (result.out_day == 5'd0) && (result.out_month == 4'd0) && (result.out_year == 16'd0))
    else $error("invalid date result not zeroed");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == gdv_pkg::ST_OK) |->
      (result.out_day != 5'd0) && (result.out_month <= gdv_pkg::MONTH_DEC))
    else $error("ok result outside calendar range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> (state == S_MOD) && (cnt == 1'b1))
    else $error("accepted beat did not start the year reduction");

  a_walk_month: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (mon <= gdv_pkg::MONTH_DEC))
    else $error("month index left range during walk");
`endif

endmodule

// File: hdl/gdv_alu.sv
module gdv_alu #(
  parameter int W = 17
) (
  input  logic         op_add,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] res,
  output logic         gt
);

  assign res = op_add ? (a + b) : (a - b);
  assign gt  = (a > b);

endmodule

// File: hdl/gdv_year_trk.sv
module gdv_year_trk (
  input  logic              clk,
  input  gdv_pkg::year_cmd_t cmd,
  input  logic [15:0]       load_year,
  output logic [15:0]       year,
  output logic              leap
);

  logic [4:0] rem25;

  // rem25 holds year mod 25; leap = div by 4 and (not div by 25 or div by 16)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= load_year;
      rem25 <= '0;
    end else if (cmd.mod_step) begin
      rem25 <= cmd.mod_rem;
    end else if (cmd.incr) begin
      year  <= year + 16'd1;
      rem25 <= (rem25 == gdv_pkg::REM_TOP) ? 5'd0 : rem25 + 5'd1;
    end
  end

  assign leap = (year[1:0] == 2'd0) && ((rem25 != 5'd0) || (year[3:0] == 4'd0));

endmodule
